/* src/tbfb_pkg.sv */
// tbfb_pkg: shared types, constants and the bcd helper for the time broadcast frame builder
// no dependencies; used by every module under src
`timescale 1ns / 1ps

package tbfb_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_OPCODE = 2'd0;
    localparam logic [1:0] CFG_START  = 2'd1;
    localparam logic [1:0] CFG_END    = 2'd2;

    // reset values of the configuration registers
    localparam logic [7:0] RST_OPCODE = 8'h00;
    localparam logic [7:0] RST_START  = 8'h01;
    localparam logic [7:0] RST_END    = 8'h04;

    // fixed frame bytes and conversion constants
    localparam logic [7:0] LEN_BIN    = 8'h08;
    localparam logic [7:0] LEN_ASC    = 8'h0d;
    localparam logic [7:0] ALT_OPCODE = 8'hb5;
    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] MIN_YEAR   = 8'd123;
    localparam logic [2:0] SUNDAY_TX  = 3'd7;

    // frame formats
    localparam logic FMT_BIN = 1'b0;
    localparam logic FMT_ASC = 1'b1;

    // byte positions within a frame
    localparam int IDX_W = 5;
    localparam logic [IDX_W-1:0] IDX_START   = 5'd0;
    localparam logic [IDX_W-1:0] IDX_DEST_HI = 5'd1;
    localparam logic [IDX_W-1:0] IDX_DEST_LO = 5'd2;
    localparam logic [IDX_W-1:0] IDX_SRC_HI  = 5'd3;
    localparam logic [IDX_W-1:0] IDX_SRC_LO  = 5'd4;
    localparam logic [IDX_W-1:0] IDX_LEN     = 5'd5;
    localparam logic [IDX_W-1:0] IDX_OP      = 5'd6;
    localparam logic [IDX_W-1:0] IDX_DATA0   = 5'd7;
    localparam logic [IDX_W-1:0] BIN_LAST    = 5'd16;
    localparam logic [IDX_W-1:0] ASC_LAST    = 5'd21;

    // one classified frame request, queued between front and back
    typedef struct packed {
        logic            fmt;
        logic [7:0]      opcode;
        logic [15:0]     dest;
        logic [15:0]     src;
        logic [7:0]      wday_bcd;
        logic [5:0][7:0] vals;
    } t_frame_desc;

    // packed bcd of a value below 100; tens through a reciprocal multiply
    function automatic logic [7:0] bcd_of(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        prod  = {8'd0, v} * 15'd205;
        tens  = prod[14:11];
        units = v - ({3'd0, tens} * 7'd10);
        return {tens, units[3:0]};
    endfunction

endpackage

/* src/time_broadcast_frame_builder.sv */
// time_broadcast_frame_builder: top level with configuration registers, front, queue and back
// depends on tbfb_pkg, tbfb_front, tbfb_queue, tbfb_back
`timescale 1ns / 1ps

// Turns one calendar-time request into a date-time broadcast frame sent one byte per output
// transaction: 17 bytes in the binary bcd format, 22 bytes in the ascii digit format, the last
// byte flagged by o_last_byte. Requests with a year below 2023 are accepted and produce nothing.
// The back end sequencer emits one byte per cycle unless i_ready stalls the output, and frames
// follow each other with no gap; a two-entry queue lets the input keep accepting while a frame
// is being sent. The first byte of a frame passes through the queue, the sequencer's descriptor
// register and the output register before it is presented. Configuration writes take effect
// on the next clock and are meant to be done while the block is idle.

module time_broadcast_frame_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_frame_format,
    input  logic        i_alt_opcode,
    input  logic [15:0] i_dest_addr,
    input  logic [15:0] i_src_addr,
    input  logic [2:0]  i_weekday,
    input  logic [4:0]  i_day_of_month,
    input  logic [3:0]  i_month_index,
    input  logic [7:0]  i_years_since_1900,
    input  logic [4:0]  i_hour,
    input  logic [5:0]  i_minute,
    input  logic [5:0]  i_second,
    // byte channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_tx_byte,
    output logic        o_last_byte
);

    logic [7:0] r_set_time_opcode;
    logic [7:0] r_start_byte;
    logic [7:0] r_end_byte;

    logic                  q_full;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_valid;
    tbfb_pkg::t_frame_desc front_desc;
    tbfb_pkg::t_frame_desc q_desc;

    // configuration registers, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_time_opcode <= tbfb_pkg::RST_OPCODE;
            r_start_byte      <= tbfb_pkg::RST_START;
            r_end_byte        <= tbfb_pkg::RST_END;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                tbfb_pkg::CFG_OPCODE: r_set_time_opcode <= i_cfg_data;
                tbfb_pkg::CFG_START:  r_start_byte      <= i_cfg_data;
                tbfb_pkg::CFG_END:    r_end_byte        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // request classification
    tbfb_front u_front (
        .i_valid            (i_valid),
        .i_frame_format     (i_frame_format),
        .i_alt_opcode       (i_alt_opcode),
        .i_dest_addr        (i_dest_addr),
        .i_src_addr         (i_src_addr),
        .i_weekday          (i_weekday),
        .i_day_of_month     (i_day_of_month),
        .i_month_index      (i_month_index),
        .i_years_since_1900 (i_years_since_1900),
        .i_hour             (i_hour),
        .i_minute           (i_minute),
        .i_second           (i_second),
        .i_set_time_opcode  (r_set_time_opcode),
        .i_q_full           (q_full),
        .o_ready            (o_ready),
        .o_push             (q_push),
        .o_desc             (front_desc)
    );

    // descriptor queue
    tbfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (front_desc),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_desc  (q_desc)
    );

    // byte sequencer
    tbfb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_desc     (q_desc),
        .o_q_pop      (q_pop),
        .i_start_byte (r_start_byte),
        .i_end_byte   (r_end_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_tx_byte    (o_tx_byte),
        .o_last_byte  (o_last_byte)
    );

endmodule

/* src/tbfb_front.sv */
// tbfb_front: classifies requests, drops early years and converts time fields to bcd
// depends on tbfb_pkg
`timescale 1ns / 1ps

module tbfb_front (
    input  logic                 i_valid,
    input  logic                 i_frame_format,
    input  logic                 i_alt_opcode,
    input  logic [15:0]          i_dest_addr,
    input  logic [15:0]          i_src_addr,
    input  logic [2:0]           i_weekday,
    input  logic [4:0]           i_day_of_month,
    input  logic [3:0]           i_month_index,
    input  logic [7:0]           i_years_since_1900,
    input  logic [4:0]           i_hour,
    input  logic [5:0]           i_minute,
    input  logic [5:0]           i_second,
    input  logic [7:0]           i_set_time_opcode,
    input  logic                 i_q_full,
    output logic                 o_ready,
    output logic                 o_push,
    output tbfb_pkg::t_frame_desc o_desc
);

    logic [7:0] year_mod;
    logic [4:0] month_tx;
    logic [2:0] wday_tx;
    logic       early;

    // queue space decides acceptance; early years are taken and dropped
    assign o_ready = !i_q_full;
    assign early   = i_years_since_1900 < tbfb_pkg::MIN_YEAR;
    assign o_push  = i_valid && !i_q_full && !early;

    // year modulo 100, valid for the accepted range 123..255
    assign year_mod = (i_years_since_1900 >= 8'd200) ? (i_years_since_1900 - 8'd200)
                                                     : (i_years_since_1900 - 8'd100);
    assign month_tx = {1'b0, i_month_index} + 5'd1;
    assign wday_tx  = (i_weekday == 3'd0) ? tbfb_pkg::SUNDAY_TX : i_weekday;

    // build the frame descriptor
    always_comb begin
        o_desc.fmt      = i_frame_format;
        o_desc.opcode   = (i_frame_format == tbfb_pkg::FMT_ASC && i_alt_opcode)
                          ? tbfb_pkg::ALT_OPCODE : i_set_time_opcode;
        o_desc.dest     = i_dest_addr;
        o_desc.src      = i_src_addr;
        o_desc.wday_bcd = {5'd0, wday_tx};
        o_desc.vals[0]  = tbfb_pkg::bcd_of({2'd0, i_day_of_month});
        o_desc.vals[1]  = tbfb_pkg::bcd_of({2'd0, month_tx});
        o_desc.vals[2]  = tbfb_pkg::bcd_of(year_mod[6:0]);
        o_desc.vals[3]  = tbfb_pkg::bcd_of({2'd0, i_hour});
        o_desc.vals[4]  = tbfb_pkg::bcd_of({1'b0, i_minute});
        o_desc.vals[5]  = tbfb_pkg::bcd_of({1'b0, i_second});
    end

endmodule

/* src/tbfb_queue.sv */
// tbfb_queue: two-entry descriptor queue between front and back
// depends on tbfb_pkg
`timescale 1ns / 1ps

module tbfb_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  tbfb_pkg::t_frame_desc i_desc,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output tbfb_pkg::t_frame_desc o_desc
);

    tbfb_pkg::t_frame_desc r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       do_pop;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_desc  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ do_pop;
        n_count  = r_count + {1'b0, i_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

endmodule

/* src/tbfb_back.sv */
// tbfb_back: byte sequencer that walks a frame descriptor and drives the output register
// depends on tbfb_pkg
`timescale 1ns / 1ps

module tbfb_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  tbfb_pkg::t_frame_desc i_q_desc,
    output logic                  o_q_pop,
    input  logic [7:0]            i_start_byte,
    input  logic [7:0]            i_end_byte,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_tx_byte,
    output logic                  o_last_byte
);

    tbfb_pkg::t_frame_desc r_desc;
    logic                       r_busy;
    logic [tbfb_pkg::IDX_W-1:0] r_idx;
    logic [15:0]                r_sum;
    logic                       r_out_valid;
    logic [7:0]                 r_out_byte;
    logic                       r_out_last;

    logic                       n_busy;
    logic [tbfb_pkg::IDX_W-1:0] n_idx;
    logic [15:0]                n_sum;

    logic                       advance;
    logic                       at_last;
    logic [tbfb_pkg::IDX_W-1:0] last_idx;
    logic [tbfb_pkg::IDX_W-1:0] rel;
    logic [tbfb_pkg::IDX_W-1:0] rel_m1;
    logic [7:0]                 digits;
    logic [7:0]                 cur_byte;
    logic                       is_data;

    // frame geometry
    assign last_idx = (r_desc.fmt == tbfb_pkg::FMT_ASC) ? tbfb_pkg::ASC_LAST
                                                        : tbfb_pkg::BIN_LAST;
    assign at_last  = r_idx == last_idx;
    assign advance  = r_busy && (!r_out_valid || i_ready);
    assign o_q_pop  = !r_busy || (advance && at_last);

    assign rel     = r_idx - tbfb_pkg::IDX_DATA0;
    assign rel_m1  = rel - 5'd1;
    assign is_data = (r_idx >= tbfb_pkg::IDX_DATA0) && (r_idx <= last_idx - 5'd3);

    // data byte for the current position
    always_comb begin
        digits = r_desc.vals[rel[3:1]];
        if (r_desc.fmt == tbfb_pkg::FMT_ASC) begin
            cur_byte = tbfb_pkg::ASCII_ZERO
                       + {4'd0, (rel[0] ? digits[3:0] : digits[7:4])};
        end else if (rel == 5'd0) begin
            cur_byte = r_desc.wday_bcd;
        end else begin
            cur_byte = r_desc.vals[rel_m1[2:0]];
        end
    end

    // byte select over the frame layout
    logic [7:0] tx_sel;
    always_comb begin
        if (r_idx == tbfb_pkg::IDX_START) begin
            tx_sel = i_start_byte;
        end else if (r_idx == tbfb_pkg::IDX_DEST_HI) begin
            tx_sel = r_desc.dest[15:8];
        end else if (r_idx == tbfb_pkg::IDX_DEST_LO) begin
            tx_sel = r_desc.dest[7:0];
        end else if (r_idx == tbfb_pkg::IDX_SRC_HI) begin
            tx_sel = r_desc.src[15:8];
        end else if (r_idx == tbfb_pkg::IDX_SRC_LO) begin
            tx_sel = r_desc.src[7:0];
        end else if (r_idx == tbfb_pkg::IDX_LEN) begin
            tx_sel = (r_desc.fmt == tbfb_pkg::FMT_ASC) ? tbfb_pkg::LEN_ASC
                                                       : tbfb_pkg::LEN_BIN;
        end else if (r_idx == tbfb_pkg::IDX_OP) begin
            tx_sel = r_desc.opcode;
        end else if (is_data) begin
            tx_sel = cur_byte;
        end else if (r_idx == last_idx - 5'd2) begin
            tx_sel = r_sum[15:8];
        end else if (r_idx == last_idx - 5'd1) begin
            tx_sel = r_sum[7:0];
        end else begin
            tx_sel = i_end_byte;
        end
    end

    // sequencer next state and running checksum
    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_sum  = r_sum;
        if (advance) begin
            n_idx = r_idx + 5'd1;
            if (r_idx == tbfb_pkg::IDX_OP) begin
                n_sum = {8'd0, r_desc.opcode};
            end else if (is_data) begin
                n_sum = r_sum + {8'd0, cur_byte};
            end
            if (at_last) begin
                n_busy = 1'b0;
            end
        end
        if (o_q_pop && i_q_valid) begin
            n_busy = 1'b1;
            n_idx  = tbfb_pkg::IDX_START;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= tbfb_pkg::IDX_START;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
        if (o_q_pop && i_q_valid) begin
            r_desc <= i_q_desc;
        end
    end

    // output register, refilled in the same cycle it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= tx_sel;
            r_out_last <= at_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_tx_byte   = r_out_byte;
    assign o_last_byte = r_out_last;

endmodule
